/* design/cgw_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the can gateway match and rewrite block
// no dependencies

package cgw_pkg;

  localparam int LOG_ENTRIES     = 3;
  localparam int REWRITE_ENTRIES = 3;

  localparam int LOG_DEPTH = 2 * LOG_ENTRIES;
  localparam int RW_DEPTH  = 2 * REWRITE_ENTRIES;
  localparam int LOG_AW    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int RW_AW     = (RW_DEPTH > 1) ? $clog2(RW_DEPTH) : 1;
  localparam int LOG_FW    = $clog2(LOG_ENTRIES + 1);
  localparam int RW_FW     = $clog2(REWRITE_ENTRIES + 1);

  // entries walked per frame, both tables in parallel
  localparam int WALK_N = (LOG_ENTRIES > REWRITE_ENTRIES) ? LOG_ENTRIES : REWRITE_ENTRIES;
  localparam int WALK_W = $clog2(WALK_N + 1);

  localparam int HIT_BITS = 3;

  localparam logic [5:0] SLOT_FIRST = 6'd24;
  localparam logic [5:0] SLOT_LAST  = 6'd32;

  typedef enum logic [1:0] {
    OP_FRAME       = 2'd0,
    OP_ADD_LOG     = 2'd1,
    OP_ADD_REWRITE = 2'd2,
    OP_CLEAR       = 2'd3
  } cgw_op_t;

  // table write request from the command side
  typedef struct packed {
    logic        log_we;
    logic        rw_we;
    logic        clr;
    logic        bus;
    logic [31:0] key;
    logic [63:0] value;
    logic [63:0] vmask;
  } cgw_wr_t;

  // registered table read data plus fill counts of the read bus
  typedef struct packed {
    logic [31:0]       log_key;
    logic [31:0]       rw_key;
    logic [63:0]       rw_value;
    logic [63:0]       rw_vmask;
    logic [LOG_FW-1:0] log_fill;
    logic [RW_FW-1:0]  rw_fill;
  } cgw_rd_t;

  // key is id in the low half, id mask in the high half
  function automatic logic key_hit(input logic [31:0] key, input logic [15:0] id);
    return (id & key[31:16]) == (key[15:0] & key[31:16]);
  endfunction

endpackage

/* design/cgw_if.sv */
`timescale 1ns / 1ps
// channel interfaces for commands in and forwarded frames out
// depends on nothing

interface cgw_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic        bus;
  logic [28:0] msg_id;
  logic [63:0] frame_data;
  logic [15:0] entry_id;
  logic [15:0] entry_mask;
  logic [63:0] entry_value;
  logic [63:0] entry_value_mask;

  modport source (output valid, opcode, bus, msg_id, frame_data, entry_id, entry_mask,
                  entry_value, entry_value_mask, input ready);
  modport sink (input valid, opcode, bus, msg_id, frame_data, entry_id, entry_mask,
                entry_value, entry_value_mask, output ready);
endinterface

interface cgw_fwd_if;
  logic        valid;
  logic        ready;
  logic        out_bus;
  logic [28:0] out_id;
  logic [63:0] out_data;
  logic [63:0] logged_data;
  logic [2:0]  log_hits;
  logic [5:0]  tx_slot;

  modport source (output valid, out_bus, out_id, out_data, logged_data, log_hits, tx_slot,
                  input ready);
  modport sink (input valid, out_bus, out_id, out_data, logged_data, log_hits, tx_slot,
                output ready);
endinterface

/* design/cgw_tables.sv */
`timescale 1ns / 1ps
// log and rewrite tables of both buses: two synchronous memories and fill counts
// depends on cgw_pkg

module cgw_tables
  import cgw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cgw_wr_t           wr,
  input  logic              rd_bus,
  input  logic [WALK_W-1:0] rd_idx,
  output cgw_rd_t           rd
);

  logic [31:0]  log_mem [LOG_DEPTH];
  logic [159:0] rw_mem  [RW_DEPTH];

  logic [LOG_FW-1:0] log_fill [2];
  logic [RW_FW-1:0]  rw_fill  [2];

  logic [LOG_AW-1:0] log_waddr, log_raddr;
  logic [RW_AW-1:0]  rw_waddr, rw_raddr;
  logic              log_room, rw_room;
  logic [31:0]       log_q;
  logic [159:0]      rw_q;

  assign log_room  = 32'(log_fill[wr.bus]) < LOG_ENTRIES;
  assign rw_room   = 32'(rw_fill[wr.bus]) < REWRITE_ENTRIES;
  assign log_waddr = LOG_AW'(wr.bus ? LOG_ENTRIES : 0) + LOG_AW'(log_fill[wr.bus]);
  assign rw_waddr  = RW_AW'(wr.bus ? REWRITE_ENTRIES : 0) + RW_AW'(rw_fill[wr.bus]);

  // out of range indexes read address 0, the caller ignores them via the fill count
  always_comb begin
    log_raddr = '0;
    rw_raddr  = '0;
    if (32'(rd_idx) < LOG_ENTRIES) begin
      log_raddr = LOG_AW'(rd_bus ? LOG_ENTRIES : 0) + LOG_AW'(rd_idx);
    end
    if (32'(rd_idx) < REWRITE_ENTRIES) begin
      rw_raddr = RW_AW'(rd_bus ? REWRITE_ENTRIES : 0) + RW_AW'(rd_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.log_we && log_room) begin
      log_mem[log_waddr] <= wr.key;
    end
    log_q <= log_mem[log_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.rw_we && rw_room) begin
      rw_mem[rw_waddr] <= {wr.vmask, wr.value, wr.key};
    end
    rw_q <= rw_mem[rw_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || wr.clr) begin
      log_fill[0] <= '0;
      log_fill[1] <= '0;
      rw_fill[0]  <= '0;
      rw_fill[1]  <= '0;
    end else begin
      if (wr.log_we && log_room) begin
        log_fill[wr.bus] <= log_fill[wr.bus] + LOG_FW'(1);
      end
      if (wr.rw_we && rw_room) begin
        rw_fill[wr.bus] <= rw_fill[wr.bus] + RW_FW'(1);
      end
    end
  end

  assign rd.log_key  = log_q;
  assign rd.rw_key   = rw_q[31:0];
  assign rd.rw_value = rw_q[95:32];
  assign rd.rw_vmask = rw_q[159:96];
  assign rd.log_fill = log_fill[rd_bus];
  assign rd.rw_fill  = rw_fill[rd_bus];

endmodule

/* design/can_gateway_match_rewrite.sv */
`timescale 1ns / 1ps
// can gateway match and rewrite: top level with frame walk sequencer and output register
// depends on cgw_pkg, cgw_if, cgw_tables
//
// usage
//   cmd carries one command per transaction: frame received, add log entry, add
//   rewrite entry, or clear all tables. table commands give no
//   result. a received frame produces one transaction on fwd: the frame sent to
//   the other bus with its rewritten payload, the original payload, the log hit
//   bits and the transmit slot (24..32, cycling per output bus).
//   a frame reads both table memories side by side, one entry index per cycle,
//   walking max(LOG_ENTRIES, REWRITE_ENTRIES) indexes before the result register
//   is loaded; the memory read latency sets the walk. cmd is ready again in the
//   cycle after the result is loaded: a new frame waits for the last one's result,
//   and table commands are taken one per cycle while no frame is in progress.
//   fwd is a registered output: while a result waits the next command is
//   accepted, and a finished frame holds in its last state until the register
//   frees. reset empties all tables and sets both transmit slots to 24; entry
//   contents are undefined until written and never read past the fill count.

module can_gateway_match_rewrite
  import cgw_pkg::*;
(
  input logic       clk,
  input logic       rst,
  cgw_cmd_if.sink   cmd,
  cgw_fwd_if.source fwd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  cgw_wr_t wr;
  cgw_rd_t rd;

  logic              cmd_acc;
  logic              frame_acc;
  logic              bus;
  logic [28:0]       msg_id;
  logic [63:0]       data;
  logic [63:0]       orig;
  logic [2:0]        hits;
  logic [WALK_W-1:0] idx;
  logic [WALK_W-1:0] rd_idx;
  logic              rd_bus;
  logic [5:0]        next_slot [2];
  logic              out_free;
  logic              last_idx;

  assign cmd.ready = (state == S_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign frame_acc = cmd_acc && (cmd.opcode == OP_FRAME);
  assign out_free  = !fwd.valid || fwd.ready;
  assign last_idx  = 32'(idx) == WALK_N - 1;

  always_comb begin
    wr.log_we = cmd_acc && (cmd.opcode == OP_ADD_LOG);
    wr.rw_we  = cmd_acc && (cmd.opcode == OP_ADD_REWRITE);
    wr.clr    = cmd_acc && (cmd.opcode == OP_CLEAR);
    wr.bus    = cmd.bus;
    wr.key    = {cmd.entry_mask, cmd.entry_id};
    wr.value  = cmd.entry_value;
    wr.vmask  = cmd.entry_value_mask;
  end

  // the read issued now returns next cycle for index idx+1
  always_comb begin
    if (state == S_IDLE) begin
      rd_bus = cmd.bus;
      rd_idx = '0;
    end else begin
      rd_bus = bus;
      rd_idx = last_idx ? '0 : idx + WALK_W'(1);
    end
  end

  cgw_tables u_tables (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .rd_bus (rd_bus),
    .rd_idx (rd_idx),
    .rd     (rd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (frame_acc) state_next = S_WALK;
      S_WALK: if (last_idx) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // frame context and per-entry match and rewrite
  always_ff @(posedge clk) begin
    if (frame_acc) begin
      bus    <= cmd.bus;
      msg_id <= cmd.msg_id;
      data   <= cmd.frame_data;
      orig   <= cmd.frame_data;
      hits   <= '0;
      idx    <= '0;
    end else if (state == S_WALK) begin
      if (32'(idx) < 32'(rd.log_fill) && key_hit(rd.log_key, msg_id[15:0])) begin
        for (int j = 0; j < HIT_BITS; j++) begin
          if (32'(idx) == j) begin
            hits[j] <= 1'b1;
          end
        end
      end
      if (32'(idx) < 32'(rd.rw_fill) && key_hit(rd.rw_key, msg_id[15:0])) begin
        data <= (data & ~rd.rw_vmask) | (rd.rw_vmask & rd.rw_value);
      end
      if (!last_idx) begin
        idx <= idx + WALK_W'(1);
      end
    end
  end

  // transmit slot per output bus
  always_ff @(posedge clk) begin
    if (rst) begin
      next_slot[0] <= SLOT_FIRST;
      next_slot[1] <= SLOT_FIRST;
    end else if (state == S_DONE && out_free) begin
      next_slot[~bus] <= (next_slot[~bus] >= SLOT_LAST) ? SLOT_FIRST
                                                        : next_slot[~bus] + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd.valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      fwd.valid <= 1'b1;
    end else if (fwd.ready) begin
      fwd.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      fwd.out_bus     <= ~bus;
      fwd.out_id      <= msg_id;
      fwd.out_data    <= data;
      fwd.logged_data <= orig;
      fwd.log_hits    <= hits;
      fwd.tx_slot     <= next_slot[~bus];
    end
  end

`ifndef SYNTHESIS
  // a result only appears after the walk finished
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(fwd.valid) |-> $past(state == S_DONE))
    else $error("forward transaction raised outside the done state");

  // a stalled result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    fwd.valid && !fwd.ready |=> $stable(fwd.out_data) && $stable(fwd.tx_slot))
    else $error("waiting forward transaction changed");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(rd.log_fill) <= LOG_ENTRIES && 32'(rd.rw_fill) <= REWRITE_ENTRIES)
    else $error("table fill count beyond table size");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    next_slot[0] >= SLOT_FIRST && next_slot[0] <= SLOT_LAST &&
    next_slot[1] >= SLOT_FIRST && next_slot[1] <= SLOT_LAST)
    else $error("transmit slot out of range");
`endif

endmodule
